// ===== hdl/tsif_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsif_pkg
// Shared types and constants of the tournament score imbalance filter.
// ----------------------------------------------------------------------------
package tsif_pkg;

	localparam int MAX_VERTICES_DEF = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int VC_W       = 5;
	localparam int IMB_W      = 8;
	localparam int CNT_W      = 40;
	localparam int IN_W       = 8;
	localparam int OUT_W      = 96;

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONLY_REGULAR = 2'd1;

	localparam logic [VC_W-1:0] VC_RESET = 5'd13;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_SUM,
		ST_TAIL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic take;
		logic sum_clr;
		logic sum_rd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic idx_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/tsif_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsif_ctrl
// Sequencer: arc loading, write drain, degree sweep and result hand-off.
// ----------------------------------------------------------------------------
module tsif_ctrl
	import tsif_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	input  sts_t sts,
	output logic in_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && in_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.sum_clr = 1'b1;
				state_d     = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_rd = 1'b1;
				if (sts.idx_last) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

// ===== hdl/tsif_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsif_dpath
// Configuration, arc position tracking, degree memory with increment
// pipeline, imbalance accumulator, host counters and output register.
// ----------------------------------------------------------------------------
module tsif_dpath
	import tsif_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  arc_bit,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [IMB_W-1:0]      imbalance,
	output logic                  length_ok,
	output logic                  keep,
	output logic [CNT_W-1:0]      hosts_seen,
	output logic [CNT_W-1:0]      regular_seen
);

	localparam int NW      = $clog2(MAX_VERTICES + 2);
	localparam int XW      = (NW > VC_W) ? NW : VC_W;
	localparam int AW      = $clog2(MAX_VERTICES);
	localparam int DW      = $clog2(MAX_VERTICES);
	localparam int TW      = DW + 1;
	localparam int MAXNEED = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
	localparam int QW      = $clog2(MAXNEED + 1);
	localparam int BW      = QW + 1;
	localparam int SW      = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) + 1);

	localparam logic [XW-1:0]    X_TWO   = XW'(2);
	localparam logic [XW-1:0]    X_MAX   = XW'(MAX_VERTICES);
	localparam logic [BW-1:0]    BIT_SAT = '1;
	localparam logic [CNT_W-1:0] CNT_SAT = '1;
	localparam logic [SW-1:0]    IMB_SAT = SW'(255);

	// configuration
	logic [VC_W-1:0] vc_q;
	logic            only_reg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q       <= VC_RESET;
			only_reg_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_VERTEX_COUNT) begin
				vc_q <= cfg_wdata[VC_W-1:0];
			end
			if (cfg_idx == CFG_ONLY_REGULAR) begin
				only_reg_q <= cfg_wdata[0];
			end
		end
	end

	logic [XW-1:0]   vc_x;
	logic [NW-1:0]   n_eff;
	logic [NW-1:0]   n_m1;
	logic [2*NW-1:0] pairs2;
	logic [QW-1:0]   need;

	assign vc_x = XW'(vc_q);

	always_comb begin
		priority if (vc_x < X_TWO) begin
			n_eff = NW'(2);
		end else if (vc_x > X_MAX) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = vc_x[NW-1:0];
		end
	end

	assign n_m1   = n_eff - NW'(1);
	assign pairs2 = (2*NW)'(n_eff) * (2*NW)'(n_m1);
	assign need   = QW'(pairs2 >> 1);

	// arc position and bit count
	logic [NW-1:0] row_q;
	logic [NW-1:0] col_q;
	logic [BW-1:0] bit_q;
	logic          inc_en;
	logic [AW-1:0] vtx;
	logic [NW-1:0] col_inc;

	assign inc_en  = cmd.take && (bit_q < BW'(need)) && (row_q < n_eff) && (col_q < n_eff);
	assign vtx     = arc_bit ? row_q[AW-1:0] : col_q[AW-1:0];
	assign col_inc = col_q + NW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= NW'(1);
			bit_q <= '0;
		end else if (cmd.finish) begin
			row_q <= '0;
			col_q <= NW'(1);
			bit_q <= '0;
		end else if (cmd.take) begin
			if (inc_en) begin
				if (col_inc >= n_eff) begin
					row_q <= row_q + NW'(1);
					col_q <= row_q + NW'(2);
				end else begin
					col_q <= col_inc;
				end
			end
			if (bit_q != BIT_SAT) begin
				bit_q <= bit_q + BW'(1);
			end
		end
	end

	// degree memory, one read and one write port
	logic [DW-1:0] deg_mem [MAX_VERTICES];
	logic [DW-1:0] rdata_q;
	logic [AW-1:0] raddr;
	logic [MAX_VERTICES-1:0] vld_q;

	logic          inc_s1;
	logic [AW-1:0] addr_s1;
	logic          inc_s2;
	logic [AW-1:0] addr_s2;
	logic [DW-1:0] wdata_s2;
	logic [DW-1:0] deg_cur;
	logic [DW-1:0] wdata;

	logic [AW-1:0] idx_q;

	assign raddr = cmd.sum_rd ? idx_q : vtx;

	always_comb begin
		priority if (inc_s2 && (addr_s2 == addr_s1)) begin
			deg_cur = wdata_s2;
		end else if (vld_q[addr_s1]) begin
			deg_cur = rdata_q;
		end else begin
			deg_cur = '0;
		end
	end

	assign wdata = deg_cur + DW'(1);

	always_ff @(posedge clk) begin
		if (inc_s1) begin
			deg_mem[addr_s1] <= wdata;
		end
		rdata_q <= deg_mem[raddr];
	end

	always_ff @(posedge clk) begin
		addr_s1  <= vtx;
		addr_s2  <= addr_s1;
		wdata_s2 <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s1 <= 1'b0;
			inc_s2 <= 1'b0;
			vld_q  <= '0;
		end else begin
			inc_s1 <= inc_en;
			inc_s2 <= inc_s1;
			if (cmd.finish) begin
				vld_q <= '0;
			end else if (inc_s1) begin
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	// imbalance sweep
	logic          sum_s1;
	logic          svld_s1;
	logic [SW-1:0] acc_q;
	logic [DW-1:0] deg_rd;
	logic [TW-1:0] twice;
	logic [TW-1:0] mid;
	logic [TW-1:0] term;

	assign deg_rd = svld_s1 ? rdata_q : '0;
	assign twice  = {deg_rd, 1'b0};
	assign mid    = TW'(n_m1);
	assign term   = (twice >= mid) ? (twice - mid) : (mid - twice);

	assign sts.idx_last = (NW'(idx_q) == n_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sum_s1  <= 1'b0;
			svld_s1 <= 1'b0;
			acc_q   <= '0;
		end else begin
			sum_s1  <= cmd.sum_rd;
			svld_s1 <= vld_q[idx_q];
			if (cmd.sum_clr) begin
				idx_q <= '0;
				acc_q <= '0;
			end else begin
				if (cmd.sum_rd) begin
					idx_q <= idx_q + AW'(1);
				end
				if (sum_s1) begin
					acc_q <= acc_q + SW'(term);
				end
			end
		end
	end

	// result
	logic             ok;
	logic             zero_imb;
	logic [CNT_W-1:0] host_q;
	logic [CNT_W-1:0] reg_q;
	logic [CNT_W-1:0] host_nx;
	logic [CNT_W-1:0] reg_nx;
	logic [IMB_W-1:0] imb_sat;
	logic             out_valid_q;
	logic [IMB_W-1:0] imb_q;
	logic             ok_q;
	logic             keep_q;

	assign ok       = (bit_q == BW'(need));
	assign zero_imb = (acc_q == '0);
	assign imb_sat  = (acc_q > IMB_SAT) ? IMB_W'(255) : IMB_W'(acc_q);
	assign host_nx  = (ok && host_q != CNT_SAT) ? host_q + CNT_W'(1) : host_q;
	assign reg_nx   = (ok && zero_imb && reg_q != CNT_SAT) ? reg_q + CNT_W'(1) : reg_q;

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_q      <= '0;
			reg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				host_q      <= host_nx;
				reg_q       <= reg_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			imb_q  <= ok ? imb_sat : '0;
			ok_q   <= ok;
			keep_q <= ok && (zero_imb == only_reg_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign imbalance    = imb_q;
	assign length_ok    = ok_q;
	assign keep         = keep_q;
	assign hosts_seen   = host_q;
	assign regular_seen = reg_q;

endmodule

// ===== hdl/tournament_score_imbalance_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_score_imbalance_filter_unit
// Score imbalance of a tournament streamed as upper-triangle arc bits.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one arc request per beat: s_tdata[0] is the arc bit of pair
//   (i,j) in row order, s_tlast marks the last bit of a line. Bits without
//   s_tlast give no result. One result request on m_* follows every line end.
//   cfg_* writes vertex_count (index 0) and only_regular_mode (index 1);
//   cfg_ready is always high. Write only while the block is idle.
// Sequence:
//   Arc bits are taken one per cycle while s_tready is high. After a line
//   end s_tready stays low while the block drains the last degree write,
//   sweeps the degree memory through its single read port, adds the last
//   term and loads the output register, which raises m_tvalid.
// Reset and stalls:
//   arst_n clears counters, the line state and the output valid, and sets
//   the registers to n = 13, irregular hosts kept. A result held on m_*
//   does not block loading of the next line; if it is still held when the
//   next line's result is ready, the block waits with s_tready low.
// ----------------------------------------------------------------------------
module tournament_score_imbalance_filter_unit
	import tsif_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // [0] arc_bit, rest zero
	input  logic                  s_tlast,   // line_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata    // imbalance, length_ok, keep,
	                                         // hosts_seen, regular_seen, zeros
);

	cmd_t             cmd;
	sts_t             sts;
	logic [IMB_W-1:0] imbalance;
	logic             length_ok;
	logic             keep;
	logic [CNT_W-1:0] hosts_seen;
	logic [CNT_W-1:0] regular_seen;

	assign cfg_ready = 1'b1;

	tsif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	tsif_dpath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_idx      (cfg_index),
		.cfg_wdata    (cfg_data),
		.arc_bit      (s_tdata[0]),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.imbalance    (imbalance),
		.length_ok    (length_ok),
		.keep         (keep),
		.hosts_seen   (hosts_seen),
		.regular_seen (regular_seen)
	);

	assign m_tdata = OUT_W'({regular_seen, hosts_seen, keep, length_ok, imbalance});

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tournament_score_imbalance_filter_unit.
// Arc requests go in on s_*, with random gaps. Result requests are taken on
// m_* with random stalls. Results are compared with a local score tally, save
// for a first, short table of lines with known results. It is followed by
// random settings of vertex count and filter mode with mostly well-formed
// lines (regular and random tournaments) and some short, long and
// overlong lines. The vertex count is also changed part way through lines.
// ----------------------------------------------------------------------------
module tb_top;
	import tsif_pkg::*;

	localparam int ITEMS_TOTAL = 1450;
	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE_CYCLES = MAX_VERTICES_DEF + 4;
	localparam int PLAN_ROWS = 27;
	localparam int MAX_PRINTS = 40;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	// lowest bit first: imbalance, length_ok, keep, hosts_seen, regular_seen, pad
	typedef struct packed {
		logic [OUT_W-91:0] pad;
		logic [CNT_W-1:0]  regular_seen;
		logic [CNT_W-1:0]  hosts_seen;
		logic              keep;
		logic              length_ok;
		logic [IMB_W-1:0]  imbalance;
	} score_t;

	typedef struct {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  arc;
		logic                  last;
		logic                  given;
		score_t                want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;

	tournament_score_imbalance_filter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// score tally
	logic [VC_W-1:0]  tally_vc = VC_RESET;
	logic             tally_regular_only = 1'b0;
	logic [7:0]       tally_deg [MAX_VERTICES_DEF];
	int unsigned      tally_row = 0;
	int unsigned      tally_col = 1;
	logic [15:0]      tally_bits = '0;
	logic [CNT_W-1:0] hosts_total = '0;
	logic [CNT_W-1:0] regular_total = '0;

	score_t pending_scores [$];

	int  errors = 0;
	bit  calm = 1'b0;
	int  arcs_sent = 0;
	int  lines_sent = 0;
	int  settings_used = 0;
	int  midline_changes = 0;
	int  results_checked = 0;
	int  valid_results = 0;
	int  regular_results = 0;
	int  kept_results = 0;

	initial begin
		foreach (tally_deg[k])
			tally_deg[k] = '0;
	end

	function automatic int unsigned eff_vertices();
		int unsigned n;
		n = 32'(tally_vc);
		if (n < 2)
			n = 2;
		if (n > MAX_VERTICES_DEF)
			n = MAX_VERTICES_DEF;
		return n;
	endfunction

	function automatic bit tally_arc(input logic arc, input logic last, output score_t res);
		int unsigned n;
		int unsigned need;
		int unsigned v;
		int unsigned twice;
		int unsigned sum;
		n = eff_vertices();
		need = n * (n - 1) / 2;
		res = '0;
		if (tally_bits < need && tally_row < n && tally_col < n) begin
			v = arc ? tally_row : tally_col;
			if (v < MAX_VERTICES_DEF)
				tally_deg[v] = tally_deg[v] + 8'd1;
			tally_col++;
			if (tally_col >= n) begin
				tally_row++;
				tally_col = tally_row + 1;
			end
		end
		if (tally_bits != 16'hFFFF)
			tally_bits++;
		if (!last)
			return 1'b0;
		if (tally_bits == need) begin
			sum = 0;
			for (int i = 0; i < n; i++) begin
				twice = 2 * tally_deg[i];
				sum += (twice >= n - 1) ? twice - (n - 1) : (n - 1) - twice;
			end
			if (hosts_total != '1)
				hosts_total++;
			if (sum == 0 && regular_total != '1)
				regular_total++;
			res.length_ok = 1'b1;
			res.keep = ((sum == 0) == tally_regular_only);
			res.imbalance = (sum > 255) ? 8'd255 : sum[7:0];
		end
		res.hosts_seen = hosts_total;
		res.regular_seen = regular_total;
		foreach (tally_deg[k])
			tally_deg[k] = '0;
		tally_row = 0;
		tally_col = 1;
		tally_bits = '0;
		return 1'b1;
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_vertex_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return CFG_DATA_W'($urandom_range(2, 6));
		if (r < 88)
			return CFG_DATA_W'($urandom_range(7, 12));
		if (r < 95)
			return CFG_DATA_W'($urandom_range(13, 16));
		if (r < 97)
			return CFG_DATA_W'($urandom_range(0, 1));
		return CFG_DATA_W'($urandom_range(17, 31));
	endfunction

	task automatic send_arc(input logic arc, input logic last, input logic given,
			input score_t want);
		int gap;
		score_t res;
		cfg_valid <= 1'b0;
		gap = (!calm && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W-1){1'b0}}, arc};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		arcs_sent++;
		if (tally_arc(arc, last, res)) begin
			lines_sent++;
			pending_scores.push_back(given ? want : res);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_VERTEX_COUNT)
			tally_vc = data;
		else if (idx == CFG_ONLY_REGULAR)
			tally_regular_only = data[0];
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic plan_row_t arc_row(input logic arc);
		plan_row_t r;
		r = '{default: '0};
		r.arc = arc;
		return r;
	endfunction

	function automatic plan_row_t end_row(input logic arc, input logic [7:0] imb,
			input logic ok, input logic keep, input logic [CNT_W-1:0] hosts,
			input logic [CNT_W-1:0] regs);
		plan_row_t r;
		r = '{default: '0};
		r.arc = arc;
		r.last = 1'b1;
		r.given = 1'b1;
		r.want.imbalance = imb;
		r.want.length_ok = ok;
		r.want.keep = keep;
		r.want.hosts_seen = hosts;
		r.want.regular_seen = regs;
		return r;
	endfunction

	// result check and receiver stalls
	int stall_left = 0;
	score_t got;
	score_t want;

	task automatic check_field(input string name, input logic [CNT_W-1:0] got_v,
			input logic [CNT_W-1:0] want_v);
		if (got_v !== want_v)
			flag_error($sformatf("result %0d %s: got %0d, want %0d",
				results_checked, name, got_v, want_v));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = score_t'(m_tdata);
				if (pending_scores.size() == 0) begin
					flag_error("result request with nothing expected");
				end else begin
					want = pending_scores.pop_front();
					check_field("imbalance", CNT_W'(got.imbalance),
						CNT_W'(want.imbalance));
					check_field("length_ok", CNT_W'(got.length_ok),
						CNT_W'(want.length_ok));
					check_field("keep", CNT_W'(got.keep), CNT_W'(want.keep));
					check_field("hosts_seen", got.hosts_seen, want.hosts_seen);
					check_field("regular_seen", got.regular_seen, want.regular_seen);
					check_field("pad", CNT_W'(got.pad), '0);
					if (want.length_ok) begin
						valid_results++;
						if (want.imbalance == '0)
							regular_results++;
					end
					if (want.keep)
						kept_results++;
				end
				results_checked++;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 30) begin
				stall_left = pick_gap() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no request moving
	int quiet = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
				$display("** tournament_score_imbalance_filter_unit: FAILED **");
				$finish;
			end
		end
	end

	plan_row_t plan [PLAN_ROWS];

	initial begin
		int unsigned n;
		int unsigned need;
		int          len;
		int          kind;
		int          half;
		int          ii;
		int          jj;
		int          lines;
		bit          wrap_done;
		bit          regular_line;
		logic        arc;
		score_t      none;

		none = '0;
		wrap_done = 1'b0;
		plan = '{
			end_row(1'b1, 8'd0, 1'b0, 1'b0, 40'd0, 40'd0),
			cfg_row(CFG_VERTEX_COUNT, 5'd2),
			cfg_row(CFG_ONLY_REGULAR, 5'd0),
			end_row(1'b1, 8'd2, 1'b1, 1'b1, 40'd1, 40'd0),
			end_row(1'b0, 8'd2, 1'b1, 1'b1, 40'd2, 40'd0),
			cfg_row(CFG_ONLY_REGULAR, 5'b11111),
			cfg_row(CFG_VERTEX_COUNT, 5'd3),
			arc_row(1'b1),
			arc_row(1'b0),
			end_row(1'b1, 8'd0, 1'b1, 1'b1, 40'd3, 40'd1),
			arc_row(1'b1),
			arc_row(1'b1),
			end_row(1'b1, 8'd4, 1'b1, 1'b0, 40'd4, 40'd1),
			arc_row(1'b1),
			arc_row(1'b0),
			arc_row(1'b1),
			end_row(1'b1, 8'd0, 1'b0, 1'b0, 40'd4, 40'd1),
			cfg_row(CFG_VERTEX_COUNT, 5'd0),
			cfg_row(CFG_ONLY_REGULAR, 5'b11110),
			end_row(1'b1, 8'd2, 1'b1, 1'b1, 40'd5, 40'd1),
			cfg_row(CFG_VERTEX_COUNT, 5'd31),
			cfg_row(CFG_SPARE_HI, 5'd2),
			end_row(1'b0, 8'd0, 1'b0, 1'b0, 40'd5, 40'd1),
			cfg_row(CFG_VERTEX_COUNT, 5'd17),
			cfg_row(CFG_SPARE_LO, 5'd3),
			arc_row(1'b0),
			end_row(1'b1, 8'd0, 1'b0, 1'b0, 40'd5, 40'd1)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].is_cfg) begin
				wait_idle();
				write_reg(plan[r].idx, plan[r].data);
			end else begin
				send_arc(plan[r].arc, plan[r].last, plan[r].given, plan[r].want);
			end
		end

		while (arcs_sent < ITEMS_TOTAL) begin
			wait_idle();
			write_reg(CFG_VERTEX_COUNT, pick_vertex_count());
			if ($urandom_range(0, 1))
				write_reg(CFG_ONLY_REGULAR, CFG_DATA_W'($urandom_range(0, 31)));
			if ($urandom_range(0, 9) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
					CFG_DATA_W'($urandom_range(0, 31)));
			settings_used++;
			calm = ($urandom_range(0, 3) == 0);
			n = eff_vertices();
			need = n * (n - 1) / 2;
			lines = (n >= 13) ? $urandom_range(1, 2) : $urandom_range(3, 12);
			repeat (lines) begin
				kind = $urandom_range(0, 99);
				regular_line = (kind < 25) && n[0];
				if (!wrap_done && arcs_sent > 700) begin
					// overlong line aimed at a narrow bit counter wrapping to a valid length
					len = 256 + need;
					wrap_done = 1'b1;
				end else if (kind < 82)
					len = need;
				else if (kind < 91)
					len = (need > 1) ? $urandom_range(1, need - 1) : 2;
				else
					len = need + $urandom_range(1, 4);
				half = (!calm && len >= 2 && $urandom_range(0, 99) < 6) ?
					$urandom_range(1, len - 1) : 0;
				ii = 0;
				jj = 1;
				for (int pos = 0; pos < len; pos++) begin
					if (half != 0 && pos == half) begin
						wait_idle();
						write_reg(CFG_VERTEX_COUNT, pick_vertex_count());
						midline_changes++;
						regular_line = 1'b0;
					end
					if (regular_line && pos < need)
						arc = ((jj - ii) <= (n - 1) / 2);
					else
						arc = 1'($urandom_range(0, 1));
					send_arc(arc, pos == len - 1, 1'b0, none);
					jj++;
					if (jj >= n) begin
						ii++;
						jj = ii + 1;
					end
				end
				if (half != 0) begin
					n = eff_vertices();
					need = n * (n - 1) / 2;
				end
				if ($urandom_range(0, 99) < 8)
					wait_idle();
			end
		end

		wait_idle();
		if (pending_scores.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_scores.size()));
		$display("summary: %0d arc bits in %0d lines over %0d settings, %0d mid-line n changes",
			arcs_sent, lines_sent, settings_used, midline_changes);
		$display("summary: %0d results checked, %0d well-formed, %0d regular, %0d kept",
			results_checked, valid_results, regular_results, kept_results);
		if (errors == 0)
			$display("** tournament_score_imbalance_filter_unit: PASSED **");
		else
			$display("** tournament_score_imbalance_filter_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/tsif_pkg.sv
hdl/tsif_ctrl.sv
hdl/tsif_dpath.sv
hdl/tournament_score_imbalance_filter_unit.sv
sim/tb_top.sv
